@@ rtl/knt_pkg.sv @@
// Shared types and constants for the k-nearest target tracker.
`default_nettype none
package knt_pkg;

  localparam int unsigned KNT_MAX_ENTRIES = 8;
  localparam int unsigned ID_W            = 16;
  localparam int unsigned DIST_W          = 24;
  localparam int unsigned LIMIT_W         = 4;
  localparam int unsigned COUNT_W         = 4;
  localparam int unsigned INDEX_W         = 3;

  localparam logic [LIMIT_W-1:0] KNT_LIMIT_RESET = 4'd8;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_OFFER = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } knt_op_t;

  typedef struct packed {
    knt_op_t              opcode;
    logic [ID_W-1:0]      object_id;
    logic [DIST_W-1:0]    distance;
    logic [INDEX_W-1:0]   read_index;
  } knt_cmd_t;

  typedef struct packed {
    logic                 accepted;
    logic [COUNT_W-1:0]   entry_count;
    logic [ID_W-1:0]      entry_object;
    logic [DIST_W-1:0]    entry_distance;
    logic                 entry_valid;
  } knt_rsp_t;

  // Broadcast from the controller to every cell of the row.
  typedef struct packed {
    logic                 write;
    logic [ID_W-1:0]      id;
    logic [DIST_W-1:0]    distance;
  } knt_ins_t;

  // What a cell hands to its right neighbor.
  typedef struct packed {
    logic                 gt;
    logic [ID_W-1:0]      id;
    logic [DIST_W-1:0]    distance;
  } knt_link_t;

endpackage
`default_nettype wire

@@ rtl/knt_cell.sv @@
// One list slot: holds an entry and shifts or loads on insertion.
`default_nettype none
module knt_cell
  import knt_pkg::*;
(
  input  wire logic              clk,
  input  wire knt_ins_t          ins,
  input  wire knt_link_t         left,
  input  wire logic              occupied,
  input  wire logic              kept,
  output knt_link_t              right,
  output logic                   ge
);

  logic [ID_W-1:0]   id;
  logic [DIST_W-1:0] distance;
  logic              gt;

  // Entry sits after the new one: it moves right by one slot.
  assign gt = kept && (distance > ins.distance);
  assign ge = occupied && (distance >= ins.distance);

  assign right.gt       = gt;
  assign right.id       = id;
  assign right.distance = distance;

  always_ff @(posedge clk) begin
    if (ins.write) begin
      if (left.gt) begin
        id       <= left.id;
        distance <= left.distance;
      end else if (gt || !kept) begin
        id       <= ins.id;
        distance <= ins.distance;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/k_nearest_target_tracker_unit.sv @@
// Top level of the k-nearest target tracker: controller plus a row of list cells.
//
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd) takes one transaction: clear,
//   offer (object_id, distance) or read (read_index). Every transaction gives
//   exactly one response on the rsp channel (rsp_valid / rsp_stall / rsp).
//   Offers go into a row of MAX_ENTRIES cells kept sorted by ascending
//   distance; each cell compares its own distance with the offer and either
//   holds, loads the offer or takes its left neighbor's entry, all at the same edge.
//   The response is registered and valid on the edge after accept.
//   Throughput: one transaction per cycle while cmd_stall is low, set by the cell
//   update and the one-deep response register.
//   cmd_stall rises only while a response waits and rsp_stall is high; the
//   response register and list then hold until the response is taken.
//   cfg_we / cfg_data write lock_limit (zero acts as one, values above
//   MAX_ENTRIES saturate); lowering it drops the farthest entries.
//   Reset empties the list, sets lock_limit to 8 and drops any pending
//   response. No clearing pass is needed.
`default_nettype none
module k_nearest_target_tracker_unit
  import knt_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = KNT_MAX_ENTRIES
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cmd_valid,
  output logic                     cmd_stall,
  input  wire knt_cmd_t            cmd,
  output logic                     rsp_valid,
  input  wire logic                rsp_stall,
  output knt_rsp_t                 rsp,
  input  wire logic                cfg_we,
  input  wire logic [LIMIT_W-1:0]  cfg_data
);

  localparam int unsigned CW   = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned LW   = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam int unsigned CMPW = (CW > INDEX_W) ? CW : INDEX_W;

  logic [LIMIT_W-1:0] lock_limit;
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic [CW-1:0]      lim;
  logic [CW-1:0]      keep_n;
  logic               full;
  logic               take;
  logic               offer_ok;
  knt_ins_t           ins;
  knt_rsp_t           rsp_next;

  knt_link_t          links [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] ge_vec;

  function automatic logic [CW-1:0] eff_limit(input logic [LIMIT_W-1:0] v);
    logic [LW-1:0] e;
    e = LW'(v);
    if (v == '0) e = LW'(1);
    if (e > LW'(MAX_ENTRIES)) e = LW'(MAX_ENTRIES);
    return CW'(e);
  endfunction

  assign cmd_stall = rsp_valid && rsp_stall;
  assign take      = cmd_valid && !cmd_stall;

  assign lim      = eff_limit(lock_limit);
  assign full     = (count >= lim);
  assign keep_n   = full ? (count - CW'(1)) : count;
  assign offer_ok = !full || (|ge_vec);

  assign ins.write    = take && (cmd.opcode == OP_OFFER) && offer_ok;
  assign ins.id       = cmd.object_id;
  assign ins.distance = cmd.distance;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    knt_link_t left;
    if (g == 0) begin : g_head
      assign left = '0;
    end else begin : g_body
      assign left = links[g-1];
    end
    knt_cell u_cell (
      .clk      (clk),
      .ins      (ins),
      .left     (left),
      .occupied (CW'(g) < count),
      .kept     (CW'(g) < keep_n),
      .right    (links[g]),
      .ge       (ge_vec[g])
    );
  end

  always_comb begin
    logic [CMPW-1:0] ridx;
    ridx       = CMPW'(cmd.read_index);
    count_next = count;
    rsp_next   = '0;
    case (cmd.opcode)
      OP_CLEAR: begin
        count_next = '0;
      end
      OP_OFFER: begin
        rsp_next.accepted = offer_ok;
        if (offer_ok) count_next = keep_n + CW'(1);
      end
      OP_READ: begin
        if (ridx < CMPW'(count)) begin
          rsp_next.entry_valid = 1'b1;
          for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (CMPW'(i) == ridx) begin
              rsp_next.entry_object   = links[i].id;
              rsp_next.entry_distance = links[i].distance;
            end
          end
        end
      end
      default: begin
        count_next = count;
      end
    endcase
    rsp_next.entry_count = COUNT_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_limit <= KNT_LIMIT_RESET;
      count      <= '0;
    end else if (cfg_we) begin
      lock_limit <= cfg_data;
      if (count > eff_limit(cfg_data)) count <= eff_limit(cfg_data);
    end else if (take) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) rsp <= rsp_next;
  end

`ifndef SYNTH
  a_count_in_limit: assert property (@(posedge clk) disable iff (rst)
    count <= lim)
    else $error("entry count above effective limit");

  a_accept_nonempty: assert property (@(posedge clk) disable iff (rst)
    ins.write |=> count != '0)
    else $error("accepted offer left the list empty");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.entry_valid |-> rsp.entry_count != '0)
    else $error("valid read reported with empty list");

  for (genvar s = 0; s + 1 < MAX_ENTRIES; s++) begin : g_sorted
    a_sorted: assert property (@(posedge clk) disable iff (rst)
      (CW'(s + 1) < count) |-> (links[s].distance <= links[s+1].distance))
      else $error("list out of order");
  end
`endif

endmodule
`default_nettype wire
